// ===== sv/imu_tf_pkg.sv =====
`timescale 1ns / 1ps

package imu_tf_pkg;

  localparam int WordCount = 9;
  localparam int WordW     = 16;
  localparam int ByteW     = 8;
  localparam int PosW      = 5;
  localparam int WordIdxW  = 4;
  localparam int InDataW   = WordCount * WordW;

  localparam logic [ByteW-1:0] FRAME_HEAD    = 8'h88;
  localparam logic [ByteW-1:0] FUNC_RAW      = 8'hA1;
  localparam logic [ByteW-1:0] FUNC_ATTITUDE = 8'hAF;
  localparam logic [ByteW-1:0] LEN_RAW       = 8'd12;
  localparam logic [ByteW-1:0] LEN_ATTITUDE  = 8'd28;

  // Position of the checksum byte for each frame kind.
  localparam logic [PosW-1:0] LAST_POS_RAW      = 5'd15;
  localparam logic [PosW-1:0] LAST_POS_ATTITUDE = 5'd31;

  localparam logic KIND_RAW      = 1'b0;
  localparam logic KIND_ATTITUDE = 1'b1;

  typedef struct packed {
    logic load;
    logic advance;
  } dp_cmd_t;

  typedef struct packed {
    logic last;
  } dp_status_t;

endpackage

// ===== sv/imu_tf_ctrl.sv =====
`timescale 1ns / 1ps

module imu_tf_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output imu_tf_pkg::dp_cmd_t    cmd,
  input  imu_tf_pkg::dp_status_t status
);
  import imu_tf_pkg::*;

  typedef enum logic {
    ST_IDLE,
    ST_SEND
  } state_t;

  state_t state_r, state_nxt;
  logic   out_done;

  assign out_tvalid = (state_r == ST_SEND);
  assign out_done   = out_tvalid && out_tready && status.last;

  // A new sample set is taken in the same cycle the checksum byte leaves.
  assign in_tready   = (state_r == ST_IDLE) || out_done;
  assign cmd.load    = in_tvalid && in_tready;
  assign cmd.advance = out_tvalid && out_tready && !status.last;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (cmd.load) begin
          state_nxt = ST_SEND;
        end
      end
      ST_SEND: begin
        if (out_done && !cmd.load) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ===== sv/imu_tf_dp.sv =====
`timescale 1ns / 1ps

module imu_tf_dp (
  input  logic                                clk,
  input  logic                                rst_n,
  input  imu_tf_pkg::dp_cmd_t                 cmd,
  output imu_tf_pkg::dp_status_t              status,
  input  logic                                in_kind,
  input  logic [imu_tf_pkg::InDataW-1:0]      in_words,
  output logic [imu_tf_pkg::ByteW-1:0]        out_byte,
  output logic                                out_last
);
  import imu_tf_pkg::*;

  logic [WordW-1:0]    words_r [WordCount];
  logic                kind_r;
  logic [PosW-1:0]     pos_r, pos_nxt;
  logic [ByteW-1:0]    sum_r, sum_nxt;
  logic [ByteW-1:0]    byte_r, byte_nxt;
  logic                last_r, last_nxt;

  logic [PosW-1:0]     off;
  logic [PosW-1:0]     att_off;
  logic [WordIdxW-1:0] word_idx;
  logic                word_sel;
  logic [WordW-1:0]    word;
  logic [ByteW-1:0]    gen_byte;
  logic [PosW-1:0]     last_pos;

  assign pos_nxt  = pos_r + 5'd1;
  assign sum_nxt  = sum_r + byte_r;
  assign last_pos = kind_r ? LAST_POS_ATTITUDE : LAST_POS_RAW;

  // Payload offset of the next byte; header, function and length come first.
  assign off     = pos_nxt - 5'd3;
  assign att_off = off - 5'd18;

  always_comb begin
    word_sel = 1'b0;
    word_idx = '0;
    if (off < 5'd12) begin
      word_sel = 1'b1;
      word_idx = off[4:1];
    end else if (kind_r && off >= 5'd18 && off < 5'd24) begin
      word_sel = 1'b1;
      word_idx = 4'd6 + {1'b0, att_off[3:1]};
    end
  end

  assign word = words_r[word_idx];

  always_comb begin
    priority if (pos_nxt == 5'd1) begin
      gen_byte = kind_r ? FUNC_ATTITUDE : FUNC_RAW;
    end else if (pos_nxt == 5'd2) begin
      gen_byte = kind_r ? LEN_ATTITUDE : LEN_RAW;
    end else if (word_sel) begin
      gen_byte = off[0] ? word[7:0] : word[15:8];
    end else begin
      gen_byte = '0;
    end
  end

  always_comb begin
    if (pos_nxt == last_pos) begin
      byte_nxt = sum_nxt;
      last_nxt = 1'b1;
    end else begin
      byte_nxt = gen_byte;
      last_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      for (int i = 0; i < WordCount; i++) begin
        words_r[i] <= in_words[i*WordW +: WordW];
      end
      kind_r <= in_kind;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r  <= '0;
      sum_r  <= '0;
      byte_r <= '0;
      last_r <= 1'b0;
    end else if (cmd.load) begin
      pos_r  <= '0;
      sum_r  <= '0;
      byte_r <= FRAME_HEAD;
      last_r <= 1'b0;
    end else if (cmd.advance) begin
      pos_r  <= pos_nxt;
      sum_r  <= sum_nxt;
      byte_r <= byte_nxt;
      last_r <= last_nxt;
    end
  end

  assign status.last = last_r;
  assign out_byte    = byte_r;
  assign out_last    = last_r;

endmodule

// ===== sv/imu_telemetry_framer_core.sv =====
`timescale 1ns / 1ps
// Channel  | Ports                    | Contents
// ---------+--------------------------+---------------------------------------------
// input    | in_tvalid/tready/tdata   | tdata: nine 16-bit sample words, tuser: kind
// result   | out_tvalid/tready/tdata  | tdata: one frame byte, tlast: checksum byte
//
// A raw frame is 16 bytes and an attitude frame 32, sent one byte per cycle while
// out_tready is high, from a single output register fed by the byte sequencer.
// The next sample set is taken in the cycle the checksum byte is transferred.
// Reset is synchronous and active low; it returns the sequencer to idle.
// A stall on the result side holds the current byte and the whole frame.

module imu_telemetry_framer_core (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // accel_x, accel_y, accel_z, rate_x, rate_y, rate_z, roll_angle, pitch_angle,
  // yaw_angle
  input  logic [imu_tf_pkg::InDataW-1:0]     in_tdata,
  // action
  input  logic                               in_tuser,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // frame_byte
  output logic [imu_tf_pkg::ByteW-1:0]       out_tdata,
  output logic                               out_tlast
);
  import imu_tf_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  imu_tf_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd),
    .status     (status)
  );

  imu_tf_dp u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .status   (status),
    .in_kind  (in_tuser),
    .in_words (in_tdata),
    .out_byte (out_tdata),
    .out_last (out_tlast)
  );

  // Every frame starts with the header byte right after the sample set arrives.
  a_frame_start: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> (out_tvalid && out_tdata == FRAME_HEAD && !out_tlast))
    else $error("frame did not start with header byte");

  // Input is taken only when no frame is pending or its checksum is leaving.
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready |-> (!out_tvalid || (out_tlast && out_tready)))
    else $error("input taken while a frame is in progress");

  // After the checksum transfer with no new sample set, the output goes quiet.
  a_frame_end: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tready && out_tlast && !(in_tvalid && in_tready)) |=> !out_tvalid)
    else $error("output still valid after the frame ended");

endmodule

// ===== bench/imu_frame_checker.sv =====
`timescale 1ns / 1ps

module imu_frame_checker (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  input  logic                               in_tready,
  input  logic [imu_tf_pkg::InDataW-1:0]     in_tdata,
  input  logic                               in_tuser,
  input  logic                               out_tvalid,
  input  logic                               out_tready,
  input  logic [imu_tf_pkg::ByteW-1:0]       out_tdata,
  input  logic                               out_tlast,
  output int                                 mismatches,
  output int                                 bytes_pending
);
  import imu_tf_pkg::*;

  typedef struct packed {
    logic [ByteW-1:0] value;
    logic             last;
  } frame_byte_t;

  frame_byte_t expected_bytes[$];
  int          reported;

  // Builds the whole frame for one sample set, checksum byte last.
  function automatic void predict_frame(input logic kind, input logic [InDataW-1:0] sample);
    logic [ByteW-1:0] len;
    logic [ByteW-1:0] func;
    logic [ByteW-1:0] b;
    logic [ByteW-1:0] sum;
    logic [WordW-1:0] word;
    int               total;
    int               off;
    int               idx;
    len   = (kind == KIND_ATTITUDE) ? LEN_ATTITUDE : LEN_RAW;
    func  = (kind == KIND_ATTITUDE) ? FUNC_ATTITUDE : FUNC_RAW;
    total = int'(len) + 4;
    sum   = '0;
    for (int p = 0; p < total - 1; p++) begin
      if (p == 0) begin
        b = FRAME_HEAD;
      end else if (p == 1) begin
        b = func;
      end else if (p == 2) begin
        b = len;
      end else begin
        off = p - 3;
        idx = -1;
        if (off < 12) begin
          idx = off / 2;
        end else if (kind == KIND_ATTITUDE && off >= 18 && off < 24) begin
          // Roll, pitch and yaw follow six zero bytes in the attitude frame.
          idx = 6 + (off - 18) / 2;
        end
        if (idx < 0) begin
          b = '0;
        end else begin
          word = sample[idx*WordW +: WordW];
          b = (off % 2 == 0) ? word[WordW-1:ByteW] : word[ByteW-1:0];
        end
      end
      sum += b;
      expected_bytes.push_back('{value: b, last: 1'b0});
    end
    expected_bytes.push_back('{value: sum, last: 1'b1});
  endfunction

  task automatic note_failure(input string msg);
    mismatches++;
    if (reported < 10) begin
      $display("%t: %s", $realtime, msg);
      reported++;
    end
  endtask

  always @(posedge clk) begin : watch
    frame_byte_t want;
    if (!rst_n) begin
      expected_bytes.delete();
      mismatches = 0;
      reported   = 0;
    end else begin
      // A frame can never start leaving in the cycle its sample set arrives,
      // so predicting before checking is safe.
      if (in_tvalid && in_tready) begin
        predict_frame(in_tuser, in_tdata);
      end
      if (out_tvalid && out_tready) begin
        if (expected_bytes.size() == 0) begin
          note_failure($sformatf("unexpected frame byte %02h last %0b", out_tdata, out_tlast));
        end else begin
          want = expected_bytes.pop_front();
          if (want.value !== out_tdata || want.last !== out_tlast) begin
            note_failure($sformatf(
              "frame byte mismatch: expected %02h last %0b, got %02h last %0b",
              want.value, want.last, out_tdata, out_tlast));
          end
        end
      end
    end
    bytes_pending = expected_bytes.size();
  end

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
  import imu_tf_pkg::*;

  localparam int CycleLimit  = 200000;
  localparam int RandomSets  = 152;
  localparam int HoldCycles  = 300;
  localparam int IdlePercent = 38;

  logic               clk;
  logic               rst_n;
  logic               in_tvalid;
  logic               in_tready;
  logic [InDataW-1:0] in_tdata;
  logic               in_tuser;
  logic               out_tvalid;
  logic               out_tready;
  logic [ByteW-1:0]   out_tdata;
  logic               out_tlast;

  int   mismatches;
  int   bytes_pending;
  int   cycle_count;
  logic idle_on;
  logic hold_req;
  logic hold_done;

  imu_telemetry_framer_core i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  imu_frame_checker i_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_tvalid     (in_tvalid),
    .in_tready     (in_tready),
    .in_tdata      (in_tdata),
    .in_tuser      (in_tuser),
    .out_tvalid    (out_tvalid),
    .out_tready    (out_tready),
    .out_tdata     (out_tdata),
    .out_tlast     (out_tlast),
    .mismatches    (mismatches),
    .bytes_pending (bytes_pending)
  );

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Result side: random stalls, plus one long hold-off so the block backs up.
  initial begin
    out_tready = 1'b0;
    hold_done  = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req && !hold_done) begin
        out_tready <= 1'b0;
        hold_done = 1'b1;
        repeat (HoldCycles) @(negedge clk);
      end else if (rst_n) begin
        out_tready <= !idle_on || ($urandom_range(99) >= IdlePercent);
      end
    end
  end

  // Presents one sample set and waits until the transfer happens.
  task automatic send_set(input logic kind, input logic [InDataW-1:0] sample);
    @(negedge clk);
    while (idle_on && $urandom_range(99) < IdlePercent) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= kind;
    in_tdata  <= sample;
    do @(posedge clk); while (!in_tready);
  endtask

  function automatic logic [InDataW-1:0] random_sample();
    logic [InDataW-1:0] sample;
    logic [WordW-1:0]   word;
    for (int w = 0; w < WordCount; w++) begin
      case ($urandom_range(9))
        0:       word = 16'h7FFF;
        1:       word = 16'h8000;
        2:       word = 16'hFFFF;
        3:       word = 16'h0000;
        default: word = WordW'($urandom_range(65535));
      endcase
      sample[w*WordW +: WordW] = word;
    end
    return sample;
  endfunction

  initial begin
    logic [InDataW-1:0] ramp;
    logic               kind;
    cycle_count = 0;
    rst_n       = 1'b0;
    in_tvalid   = 1'b0;
    in_tuser    = KIND_RAW;
    in_tdata    = '0;
    idle_on     = 1'b0;
    hold_req    = 1'b0;
    for (int w = 0; w < WordCount; w++) begin
      ramp[w*WordW +: WordW] = {8'(2*w + 1), 8'(2*w + 2)};
    end
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed sets run back to back with no idling on either side.
    for (int k = 0; k < 2; k++) begin
      kind = (k == 0) ? KIND_RAW : KIND_ATTITUDE;
      send_set(kind, {WordCount{16'h0000}});
      send_set(kind, {WordCount{16'hFFFF}});
      send_set(kind, {WordCount{16'h7FFF}});
      send_set(kind, {WordCount{16'h8000}});
      send_set(kind, {WordCount{16'h0001}});
      send_set(kind, {WordCount{16'hA5A5}});
      send_set(kind, {WordCount{16'h5A5A}});
      send_set(kind, ramp);
    end
    // Angles latched in a raw frame must not show up anywhere in it.
    send_set(KIND_RAW, {{3{16'hFFFF}}, {6{16'h0000}}});
    send_set(KIND_ATTITUDE, {{3{16'hFFFF}}, {6{16'h0000}}});

    for (int i = 0; i < RandomSets; i++) begin
      idle_on = !(i >= 60 && i < 100);
      if (i == 120) begin
        hold_req = 1'b1;
      end
      send_set(KIND_ATTITUDE ^ ($urandom_range(1) == 0), random_sample());
    end
    @(negedge clk);
    in_tvalid <= 1'b0;

    while (bytes_pending != 0) @(negedge clk);
    repeat (40) @(posedge clk);
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
